@@ src/assert_macros.svh @@
// Shared assertion macros for the buffer pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/bfpool_pkg.sv @@
package bfpool_pkg;

    // Pool geometry and field widths.
    localparam int DEF_FREE_SLOTS  = 16;
    localparam int MAX_SIDE        = 16384;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int SIDE_W          = 15;
    localparam int HANDLE_W        = 16;
    localparam int BYTES_W         = 35;
    localparam int PROD_W          = 2 * SIDE_W;

    localparam logic [BYTES_W-1:0] BYTES_MAX   = {BYTES_W{1'b1}};
    localparam logic [BYTES_W-1:0] LIMIT_RESET = BYTES_W'(268435456);

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_POOL  = 2'd0,
        KIND_NEW   = 2'd1,
        KIND_EVICT = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_GRANT,
        ST_FULL_EVICT,
        ST_APPEND,
        ST_CHECK,
        ST_DONE,
        ST_EVICT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic decode;
        logic scan_step;
        logic grant;
        logic full_evict;
        logic append;
        logic emit_pend;
        logic emit_done;
        logic evict;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic handle_zero;
        logic list_full;
        logic scan_done;
        logic out_free;
        logic pend_valid;
        logic need_evict;
        logic evict_more;
    } dp_stat_t;

    // Saturate a side to the largest supported value.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if ({2'b00, v} > (SIDE_W + 2)'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

@@ src/best_fit_pool_with_fifo_eviction_core.sv @@
// Best-fit pool of two-dimensional buffers. An acquire transaction (req_type 0) returns the
// free buffer of smallest byte size whose width and height both cover the request, the oldest
// on a tie, or a fresh nonzero handle when none fits. A release transaction (req_type 1) evicts
// the oldest entry if the list is full, appends the buffer to the free list and then evicts from
// the oldest end while the free bytes exceed byte_limit, one result per eviction, with last set
// on the final result of the transaction; a release of handle zero, or one that evicts nothing,
// returns a done result. One transaction is handled at a time. The scan checks one free entry
// per cycle; evictions leave one per cycle from the oldest entry while the output is not stalled.
// A new byte_limit is used from the next eviction check on.

module best_fit_pool_with_fifo_eviction_core
    import bfpool_pkg::*;
#(
    parameter int FREE_SLOTS = DEF_FREE_SLOTS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [BYTES_W-1:0]  cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  logic [SIDE_W-1:0]   width,
    input  logic [SIDE_W-1:0]   height,
    input  logic [HANDLE_W-1:0] handle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [SIDE_W-1:0]   out_width,
    output logic [SIDE_W-1:0]   out_height,
    output logic                last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing of one transaction.
    bfpool_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Free list, scan and output register.
    bfpool_dp #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .width      (width),
        .height     (height),
        .handle     (handle),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .kind       (kind),
        .out_handle (out_handle),
        .out_width  (out_width),
        .out_height (out_height),
        .last       (last)
    );

endmodule

@@ src/bfpool_ctrl.sv @@
`include "assert_macros.svh"

module bfpool_ctrl
    import bfpool_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.is_release)
                begin
                    state_next = ST_SCAN;
                end
                else if (stat.handle_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.list_full)
                begin
                    state_next = ST_FULL_EVICT;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FULL_EVICT:
            begin
                state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.pend_valid)
                begin
                    if (stat.out_free)
                    begin
                        state_next = stat.need_evict ? ST_EVICT : ST_IDLE;
                    end
                end
                else if (stat.need_evict)
                begin
                    state_next = ST_EVICT;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVICT:
            begin
                if (stat.out_free && !stat.evict_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_req = in_valid;
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_step = !stat.scan_done;
            end
            ST_GRANT:
            begin
                cmd.grant = stat.out_free;
            end
            ST_FULL_EVICT:
            begin
                cmd.full_evict = 1'b1;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
            end
            ST_CHECK:
            begin
                if (stat.pend_valid)
                begin
                    cmd.emit_pend = stat.out_free;
                end
                else if (!stat.need_evict)
                begin
                    cmd.emit_done = stat.out_free;
                end
            end
            ST_DONE:
            begin
                cmd.emit_done = stat.out_free;
            end
            ST_EVICT:
            begin
                cmd.evict = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A result is only produced when the output register can take it.
    `ASSERT_AT_CLK(a_emit_when_free, (cmd.grant || cmd.evict || cmd.emit_pend || cmd.emit_done) |-> stat.out_free, "result issued while output register busy")
    // The grant step only follows a finished scan.
    `ASSERT_AT_CLK(a_grant_after_scan, (state_reg == ST_GRANT) |-> stat.scan_done, "grant before scan finished")

endmodule

@@ src/bfpool_dp.sv @@
`include "assert_macros.svh"

module bfpool_dp
    import bfpool_pkg::*;
#(
    parameter int FREE_SLOTS = DEF_FREE_SLOTS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [BYTES_W-1:0]  cfg_data,
    input  logic                req_type,
    input  logic [SIDE_W-1:0]   width,
    input  logic [SIDE_W-1:0]   height,
    input  logic [HANDLE_W-1:0] handle,
    input  logic                out_stall,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic                out_valid,
    output logic [1:0]          kind,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [SIDE_W-1:0]   out_width,
    output logic [SIDE_W-1:0]   out_height,
    output logic                last
);

    localparam int IDX_W = $clog2(FREE_SLOTS);
    localparam int CNT_W = $clog2(FREE_SLOTS + 1);

    // Free list storage, oldest entry at index zero.
    logic [HANDLE_W-1:0] slot_handle_reg [FREE_SLOTS];
    logic [SIDE_W-1:0]   slot_width_reg  [FREE_SLOTS];
    logic [SIDE_W-1:0]   slot_height_reg [FREE_SLOTS];
    logic [BYTES_W-1:0]  slot_bytes_reg  [FREE_SLOTS];

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [BYTES_W-1:0]  pooled_reg, pooled_next;
    logic [HANDLE_W-1:0] new_handle_reg, new_handle_next;
    logic [BYTES_W-1:0]  limit_reg;

    // Current transaction.
    logic                req_release_reg;
    logic [SIDE_W-1:0]   req_width_reg;
    logic [SIDE_W-1:0]   req_height_reg;
    logic [HANDLE_W-1:0] req_handle_reg;
    logic [BYTES_W-1:0]  req_bytes_reg;

    // Scan state and best candidate.
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [BYTES_W-1:0]  best_bytes_reg;
    logic [HANDLE_W-1:0] best_handle_reg;
    logic [SIDE_W-1:0]   best_width_reg;
    logic [SIDE_W-1:0]   best_height_reg;

    // Entry evicted ahead of an append into a full list.
    logic                pend_valid_reg;
    logic [HANDLE_W-1:0] pend_handle_reg;
    logic [SIDE_W-1:0]   pend_width_reg;
    logic [SIDE_W-1:0]   pend_height_reg;

    // Output register.
    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [SIDE_W-1:0]   out_width_reg;
    logic [SIDE_W-1:0]   out_height_reg;
    logic                out_last_reg;

    logic [PROD_W-1:0]   area;
    logic [IDX_W-1:0]    scan_idx;
    logic                scan_better;
    logic                remove;
    logic [IDX_W-1:0]    remove_idx;
    logic [BYTES_W-1:0]  remove_bytes;
    logic [BYTES_W-1:0]  pooled_less_oldest;
    logic [BYTES_W:0]    pooled_sum;
    logic                out_free;
    logic                need_evict;
    logic [HANDLE_W-1:0] grant_handle;
    logic [HANDLE_W-1:0] handle_inc;

    // Pixel area of the request; the byte factor is a constant multiply.
    assign area = PROD_W'(req_width_reg) * PROD_W'(req_height_reg);

    // Candidate test for the entry under scan.
    assign scan_idx    = scan_cnt_reg[IDX_W-1:0];
    assign scan_better = (slot_width_reg[scan_idx] >= req_width_reg)
                      && (slot_height_reg[scan_idx] >= req_height_reg)
                      && (!found_reg || (slot_bytes_reg[scan_idx] < best_bytes_reg));

    // Removal of one entry: the best fit on a grant, otherwise the oldest.
    assign remove       = (cmd.grant && found_reg) || cmd.full_evict || cmd.evict;
    assign remove_idx   = cmd.grant ? best_idx_reg : '0;
    assign remove_bytes = cmd.grant ? best_bytes_reg : slot_bytes_reg[0];

    assign pooled_less_oldest = (pooled_reg >= slot_bytes_reg[0])
                              ? pooled_reg - slot_bytes_reg[0] : '0;
    assign pooled_sum = {1'b0, pooled_reg} + {1'b0, req_bytes_reg};

    assign out_free   = !out_valid_reg || !out_stall;
    assign need_evict = (pooled_reg > limit_reg) && (count_reg != '0);

    // Fresh handles skip zero.
    assign grant_handle = (new_handle_reg == '0) ? HANDLE_W'(1) : new_handle_reg;
    assign handle_inc   = grant_handle + HANDLE_W'(1);

    // Status toward the controller.
    always_comb
    begin
        stat.is_release  = req_release_reg;
        stat.handle_zero = (req_handle_reg == '0);
        stat.list_full   = (count_reg >= CNT_W'(FREE_SLOTS));
        stat.scan_done   = (scan_cnt_reg >= count_reg);
        stat.out_free    = out_free;
        stat.pend_valid  = pend_valid_reg;
        stat.need_evict  = need_evict;
        stat.evict_more  = (pooled_less_oldest > limit_reg) && (count_reg > CNT_W'(1));
    end

    // Next values of the list bookkeeping.
    always_comb
    begin
        count_next      = count_reg;
        pooled_next     = pooled_reg;
        new_handle_next = new_handle_reg;
        if (remove)
        begin
            count_next  = count_reg - CNT_W'(1);
            pooled_next = (pooled_reg >= remove_bytes) ? pooled_reg - remove_bytes : '0;
        end
        else if (cmd.append)
        begin
            count_next  = count_reg + CNT_W'(1);
            pooled_next = pooled_sum[BYTES_W] ? BYTES_MAX : pooled_sum[BYTES_W-1:0];
        end
        if (cmd.grant && !found_reg)
        begin
            new_handle_next = (handle_inc == '0) ? HANDLE_W'(1) : handle_inc;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pooled_reg     <= '0;
            new_handle_reg <= HANDLE_W'(1);
            limit_reg      <= LIMIT_RESET;
            scan_cnt_reg   <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pooled_reg     <= pooled_next;
            new_handle_reg <= new_handle_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.decode)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                if (scan_better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.full_evict)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.emit_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.grant || cmd.evict || cmd.emit_pend || cmd.emit_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction, scan and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_release_reg <= req_type;
            req_width_reg   <= clamp_side(width);
            req_height_reg  <= clamp_side(height);
            req_handle_reg  <= handle;
        end
        if (cmd.decode)
        begin
            req_bytes_reg <= BYTES_W'(area) * BYTES_W'(BYTES_PER_PIXEL);
        end
        if (cmd.scan_step && scan_better)
        begin
            best_idx_reg    <= scan_idx;
            best_bytes_reg  <= slot_bytes_reg[scan_idx];
            best_handle_reg <= slot_handle_reg[scan_idx];
            best_width_reg  <= slot_width_reg[scan_idx];
            best_height_reg <= slot_height_reg[scan_idx];
        end
        if (cmd.full_evict)
        begin
            pend_handle_reg <= slot_handle_reg[0];
            pend_width_reg  <= slot_width_reg[0];
            pend_height_reg <= slot_height_reg[0];
        end
        if (cmd.grant)
        begin
            out_last_reg <= 1'b1;
            if (found_reg)
            begin
                out_kind_reg   <= KIND_POOL;
                out_handle_reg <= best_handle_reg;
                out_width_reg  <= best_width_reg;
                out_height_reg <= best_height_reg;
            end
            else
            begin
                out_kind_reg   <= KIND_NEW;
                out_handle_reg <= grant_handle;
                out_width_reg  <= req_width_reg;
                out_height_reg <= req_height_reg;
            end
        end
        else if (cmd.evict)
        begin
            out_kind_reg   <= KIND_EVICT;
            out_handle_reg <= slot_handle_reg[0];
            out_width_reg  <= slot_width_reg[0];
            out_height_reg <= slot_height_reg[0];
            out_last_reg   <= !stat.evict_more;
        end
        else if (cmd.emit_pend)
        begin
            out_kind_reg   <= KIND_EVICT;
            out_handle_reg <= pend_handle_reg;
            out_width_reg  <= pend_width_reg;
            out_height_reg <= pend_height_reg;
            out_last_reg   <= !need_evict;
        end
        else if (cmd.emit_done)
        begin
            out_kind_reg   <= KIND_DONE;
            out_handle_reg <= '0;
            out_width_reg  <= '0;
            out_height_reg <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    // Free list: shift newer entries down over a removed one, append at the tail.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < FREE_SLOTS; j++)
        begin
            if (remove)
            begin
                if ((j < FREE_SLOTS - 1) && (IDX_W'(j) >= remove_idx))
                begin
                    slot_handle_reg[j] <= slot_handle_reg[(j + 1) % FREE_SLOTS];
                    slot_width_reg[j]  <= slot_width_reg[(j + 1) % FREE_SLOTS];
                    slot_height_reg[j] <= slot_height_reg[(j + 1) % FREE_SLOTS];
                    slot_bytes_reg[j]  <= slot_bytes_reg[(j + 1) % FREE_SLOTS];
                end
            end
            else if (cmd.append && (IDX_W'(j) == count_reg[IDX_W-1:0]))
            begin
                slot_handle_reg[j] <= req_handle_reg;
                slot_width_reg[j]  <= req_width_reg;
                slot_height_reg[j] <= req_height_reg;
                slot_bytes_reg[j]  <= req_bytes_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign out_handle = out_handle_reg;
    assign out_width  = out_width_reg;
    assign out_height = out_height_reg;
    assign last       = out_last_reg;

    // The list never holds more entries than it has slots.
    `ASSERT_NEVER(a_count_range, count_reg > CNT_W'(FREE_SLOTS), "free list count overflow")
    // An eviction held for a full list leaves room for the append.
    `ASSERT_AT_CLK(a_pend_room, pend_valid_reg |-> (count_reg <= CNT_W'(FREE_SLOTS)) && !cmd.full_evict, "held eviction overlaps another")

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import bfpool_pkg::*;

    // One request to the pool as the driver presents it.
    typedef struct packed {
        logic                req;
        logic [SIDE_W-1:0]   w;
        logic [SIDE_W-1:0]   h;
        logic [HANDLE_W-1:0] hd;
    } pool_req_t;

    // One result of the pool as the monitor expects it.
    typedef struct packed {
        kind_t               k;
        logic [HANDLE_W-1:0] hd;
        logic [SIDE_W-1:0]   w;
        logic [SIDE_W-1:0]   h;
        logic                last;
    } pool_res_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [BYTES_W-1:0]  cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                req_type;
    logic [SIDE_W-1:0]   width;
    logic [SIDE_W-1:0]   height;
    logic [HANDLE_W-1:0] handle;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] out_handle;
    logic [SIDE_W-1:0]   out_width;
    logic [SIDE_W-1:0]   out_height;
    logic                last;

    best_fit_pool_with_fifo_eviction_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .width      (width),
        .height     (height),
        .handle     (handle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_handle (out_handle),
        .out_width  (out_width),
        .out_height (out_height),
        .last       (last)
    );

    // Pending requests, expected results and the predicted pool state.
    pool_req_t           req_q[$];
    pool_res_t           result_q[$];
    logic [HANDLE_W-1:0] free_hd[DEF_FREE_SLOTS];
    logic [SIDE_W-1:0]   free_w[DEF_FREE_SLOTS];
    logic [SIDE_W-1:0]   free_h[DEF_FREE_SLOTS];
    int                  free_count;
    logic [BYTES_W-1:0]  free_bytes;
    logic [HANDLE_W-1:0] fresh_hd;
    logic [BYTES_W-1:0]  byte_cap;

    int          errors;
    int          cycles;
    logic        in_fire;
    logic        fast_mode;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    logic [31:0] stall_ctr;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Count one mismatch and print it while no more than 50 have been counted.
    task automatic report(input string msg);
        errors++;
        if (errors <= 50)
        begin
            $display("ERROR at cycle %0d: %s", cycles, msg);
        end
    endtask

    function automatic logic [SIDE_W-1:0] saturate_side(input logic [SIDE_W-1:0] v);
        return (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
    endfunction

    function automatic logic [BYTES_W-1:0] buffer_bytes(input logic [SIDE_W-1:0] w,
                                                        input logic [SIDE_W-1:0] h);
        return BYTES_W'(w) * BYTES_W'(h) * BYTES_W'(BYTES_PER_PIXEL);
    endfunction

    // Append one expected result at the tail of the queue.
    function automatic void add_result(input pool_res_t r);
        result_q.insert(result_q.size(), r);
    endfunction

    // Take entry i off the free list, keeping the age order of the rest.
    function automatic void drop_entry(input int i);
        logic [BYTES_W-1:0] s;
        s = buffer_bytes(free_w[i], free_h[i]);
        free_bytes = (free_bytes >= s) ? free_bytes - s : '0;
        for (int j = i; j + 1 < free_count; j++)
        begin
            free_hd[j] = free_hd[j + 1];
            free_w[j]  = free_w[j + 1];
            free_h[j]  = free_h[j + 1];
        end
        free_count--;
    endfunction

    function automatic void evict_oldest_entry();
        add_result('{KIND_EVICT, free_hd[0], free_w[0], free_h[0], 1'b0});
        drop_entry(0);
    endfunction

    // Work out the results of one accepted request and update the pool state.
    function automatic void predict_pool(input pool_req_t r);
        logic [SIDE_W-1:0]  w;
        logic [SIDE_W-1:0]  h;
        logic [BYTES_W-1:0] s;
        logic [BYTES_W-1:0] best_s;
        logic [BYTES_W:0]   sum;
        logic               found;
        int                 best;
        int                 evicted;
        w = saturate_side(r.w);
        h = saturate_side(r.h);
        found = 1'b0;
        best = 0;
        best_s = '0;
        evicted = 0;
        if (!r.req)
        begin
            for (int i = 0; i < free_count; i++)
            begin
                if (free_w[i] >= w && free_h[i] >= h)
                begin
                    s = buffer_bytes(free_w[i], free_h[i]);
                    if (!found || s < best_s)
                    begin
                        found = 1'b1;
                        best = i;
                        best_s = s;
                    end
                end
            end
            if (found)
            begin
                add_result('{KIND_POOL, free_hd[best], free_w[best], free_h[best], 1'b1});
                drop_entry(best);
            end
            else
            begin
                add_result('{KIND_NEW, fresh_hd, w, h, 1'b1});
                fresh_hd = (fresh_hd == '1) ? HANDLE_W'(1) : fresh_hd + 1'b1;
            end
        end
        else if (r.hd == '0)
        begin
            add_result('{KIND_DONE, '0, '0, '0, 1'b1});
        end
        else
        begin
            if (free_count >= DEF_FREE_SLOTS)
            begin
                evict_oldest_entry();
                evicted++;
            end
            free_hd[free_count] = r.hd;
            free_w[free_count]  = w;
            free_h[free_count]  = h;
            free_count++;
            sum = {1'b0, free_bytes} + {1'b0, buffer_bytes(w, h)};
            free_bytes = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
            while (free_bytes > byte_cap && free_count > 0)
            begin
                evict_oldest_entry();
                evicted++;
            end
            if (evicted == 0)
            begin
                add_result('{KIND_DONE, '0, '0, '0, 1'b1});
            end
            else
            begin
                result_q[result_q.size() - 1].last = 1'b1;
            end
        end
    endfunction

    // Accept monitor: predicts each accepted request and checks each result.
    always @(posedge clk)
    begin
        pool_res_t e;
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                predict_pool('{req_type, width, height, handle});
            end
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    report($sformatf("unexpected result kind %0d handle %0d", kind, out_handle));
                end
                else
                begin
                    e = result_q.pop_front();
                    if (kind !== e.k)
                        report($sformatf("kind %0d, expected %0d", kind, e.k));
                    if (out_handle !== e.hd)
                        report($sformatf("handle %0d, expected %0d", out_handle, e.hd));
                    if (out_width !== e.w)
                        report($sformatf("width %0d, expected %0d", out_width, e.w));
                    if (out_height !== e.h)
                        report($sformatf("height %0d, expected %0d", out_height, e.h));
                    if (last !== e.last)
                        report($sformatf("last %0d, expected %0d", last, e.last));
                end
            end
        end
        else
        begin
            in_fire <= 1'b0;
        end
    end

    // Request driver: presents queued requests in bursts with random gaps.
    always @(negedge clk)
    begin
        pool_req_t r;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left > 0 && !fast_mode)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() > 0)
            begin
                r = req_q.pop_front();
                in_valid <= 1'b1;
                req_type <= r.req;
                width    <= r.w;
                height   <= r.h;
                handle   <= r.hd;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 10);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result stall pattern: picks a new random mode whenever the low six bits of its counter are zero.
    always @(negedge clk)
    begin
        stall_ctr++;
        if (stall_ctr[5:0] == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        if (fast_mode || !rst_n)
            out_stall <= 1'b0;
        else
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                2: out_stall <= stall_ctr[1];
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 1500000)
        begin
            $display("best_fit_pool_with_fifo_eviction_core test failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (req_q.size() != 0 || in_valid || result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic set_limit(input logic [BYTES_W-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_data  <= v;
        byte_cap = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_req(input logic rq, input int w, input int h, input int hd);
        req_q.insert(req_q.size(), '{rq, SIDE_W'(w), SIDE_W'(h), HANDLE_W'(hd)});
    endtask

    function automatic int pick_side();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6)
            return $urandom_range(1, 16);
        else if (p == 6)
            return $urandom_range(1, 64);
        else if (p == 7)
            return $urandom_range(0, 32767);
        else if (p == 8)
            return $urandom_range(16380, 16400);
        return $urandom_range(0, 4096);
    endfunction

    function automatic int pick_handle();
        if ($urandom_range(0, 15) == 0)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(1, 40);
    endfunction

    // Random phase: mostly releases followed by fitting acquires, some noise.
    task automatic random_phase(input int n);
        int w;
        int h;
        for (int i = 0; i < n; i++)
        begin
            w = pick_side();
            h = pick_side();
            if ($urandom_range(0, 4) != 0)
            begin
                push_req(1'b1, w, h, pick_handle());
                if ($urandom_range(0, 1) == 0)
                begin
                    push_req(1'b0, $urandom_range(0, w), $urandom_range(0, h),
                             $urandom_range(0, 65535));
                    i++;
                end
            end
            else
            begin
                push_req(1'($urandom_range(0, 1)), w, h, pick_handle());
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = 1'b0;
        width = '0;
        height = '0;
        handle = '0;
        out_stall = 1'b0;
        in_fire = 1'b0;
        fast_mode = 1'b0;
        burst_left = 1;
        gap_left = 0;
        stall_mode = 0;
        stall_ctr = '0;
        errors = 0;
        cycles = 0;
        free_count = 0;
        free_bytes = '0;
        fresh_hd = HANDLE_W'(1);
        byte_cap = LIMIT_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset limit.
        push_req(1'b0, 10, 10, 0);          // empty pool grants a fresh handle
        push_req(1'b1, 7, 7, 0);            // release of handle zero is ignored
        push_req(1'b1, 100, 50, 5);
        push_req(1'b1, 50, 100, 6);         // same byte size as handle 5
        push_req(1'b1, 200, 200, 7);
        push_req(1'b0, 40, 40, 65535);      // tie goes to the oldest entry
        push_req(1'b0, 150, 10, 0);         // only the large entry fits
        push_req(1'b1, 32767, 20000, 8);    // oversized sides saturate and flush
        push_req(1'b1, 0, 5, 9);            // zero side gives zero bytes
        push_req(1'b1, 3, 0, 9);            // duplicate release is stored twice
        push_req(1'b0, 0, 0, 0);
        for (int i = 0; i < 16; i++)
        begin
            push_req(1'b1, 2, 2, 100 + i);  // the last one overflows the list
        end
        push_req(1'b1, 16384, 16384, 65535); // maximum result count
        push_req(1'b0, 1, 1, 0);
        wait_idle();

        // Back-to-back acquires with no idling on either side.
        set_limit(BYTES_MAX);
        fast_mode = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            push_req(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767),
                     $urandom_range(0, 65535));
        end
        wait_idle();
        fast_mode = 1'b0;

        // Random phases across limits, extremes included.
        random_phase(25);
        set_limit('0);
        random_phase(25);
        set_limit(BYTES_W'(1) << 20);
        random_phase(25);
        set_limit(BYTES_W'(20000));
        random_phase(25);
        set_limit({3'($urandom_range(0, 7)), $urandom});
        random_phase(25);
        set_limit(LIMIT_RESET);
        random_phase(25);

        if (errors == 0)
        begin
            $display("best_fit_pool_with_fifo_eviction_core test passed");
        end
        else
        begin
            $display("best_fit_pool_with_fifo_eviction_core test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/bfpool_pkg.sv
src/bfpool_ctrl.sv
src/bfpool_dp.sv
src/best_fit_pool_with_fifo_eviction_core.sv
tb/tb_top.sv
